>>> rtl/tar_pkg.sv
// ----------------------------------------------------------------------------
// tar_pkg
// Shared types and constants for the tensor axis reduction block.
// ----------------------------------------------------------------------------
package tar_pkg;

	localparam int VAL_W     = 32;
	localparam int ACC_W     = 48;
	localparam int IDX_W     = 12;
	localparam int DIM_REG_W = 11;
	localparam int NUM_DIM   = 4;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PW      = 2;

	// mode codes
	localparam logic [1:0] MODE_SUM = 2'd0;
	localparam logic [1:0] MODE_ALL = 2'd1;
	localparam logic [1:0] MODE_ANY = 2'd2;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_RANK  = 3'd1;
	localparam logic [2:0] REG_MASK  = 3'd2;
	localparam logic [2:0] REG_DIM0  = 3'd3;
	localparam logic [2:0] REG_DIM1  = 3'd4;
	localparam logic [2:0] REG_DIM2  = 3'd5;
	localparam logic [2:0] REG_DIM3  = 3'd6;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic [1:0]                            mode;
		logic [2:0]                            rank;
		logic [3:0]                            axis_mask;
		logic [NUM_DIM-1:0][DIM_REG_W-1:0]     dim;
	} cfg_t;

	// classification of one element, set by the front end
	typedef struct packed {
		logic first;
		logic last_out;
		logic last_all;
	} tag_t;

endpackage

>>> rtl/tar_cfg.sv
// ----------------------------------------------------------------------------
// tar_cfg
// APB register file: mode, rank, axis mask and the four dimension sizes.
// ----------------------------------------------------------------------------
module tar_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tar_pkg::ADDR_W-1:0]   paddr,
	input  logic [tar_pkg::DATA_W-1:0]   pwdata,
	output logic [tar_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output tar_pkg::cfg_t                cfg,
	output logic                         restart
);

	tar_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// any write to a defined register restarts the tensor walk
	always_comb begin
		unique case (idx)
			tar_pkg::REG_MODE, tar_pkg::REG_RANK, tar_pkg::REG_MASK,
			tar_pkg::REG_DIM0, tar_pkg::REG_DIM1, tar_pkg::REG_DIM2,
			tar_pkg::REG_DIM3: restart = wr;
			default:           restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= tar_pkg::MODE_SUM;
			cfg_q.rank      <= 3'd4;
			cfg_q.axis_mask <= 4'd0;
			for (int d = 0; d < tar_pkg::NUM_DIM; d++) begin
				cfg_q.dim[d] <= tar_pkg::DIM_REG_W'(1);
			end
		end else if (wr) begin
			unique case (idx)
				tar_pkg::REG_MODE: cfg_q.mode      <= pwdata[1:0];
				tar_pkg::REG_RANK: cfg_q.rank      <= pwdata[2:0];
				tar_pkg::REG_MASK: cfg_q.axis_mask <= pwdata[3:0];
				tar_pkg::REG_DIM0: cfg_q.dim[0]    <= pwdata[tar_pkg::DIM_REG_W-1:0];
				tar_pkg::REG_DIM1: cfg_q.dim[1]    <= pwdata[tar_pkg::DIM_REG_W-1:0];
				tar_pkg::REG_DIM2: cfg_q.dim[2]    <= pwdata[tar_pkg::DIM_REG_W-1:0];
				tar_pkg::REG_DIM3: cfg_q.dim[3]    <= pwdata[tar_pkg::DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tar_pkg::REG_MODE: prdata = tar_pkg::DATA_W'(cfg_q.mode);
			tar_pkg::REG_RANK: prdata = tar_pkg::DATA_W'(cfg_q.rank);
			tar_pkg::REG_MASK: prdata = tar_pkg::DATA_W'(cfg_q.axis_mask);
			tar_pkg::REG_DIM0: prdata = tar_pkg::DATA_W'(cfg_q.dim[0]);
			tar_pkg::REG_DIM1: prdata = tar_pkg::DATA_W'(cfg_q.dim[1]);
			tar_pkg::REG_DIM2: prdata = tar_pkg::DATA_W'(cfg_q.dim[2]);
			tar_pkg::REG_DIM3: prdata = tar_pkg::DATA_W'(cfg_q.dim[3]);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> rtl/tar_front.sv
// ----------------------------------------------------------------------------
// tar_front
// Walks the row-major coordinates, classifies each element (first / last
// contribution to its output, last of tensor) and tracks its output slot.
// ----------------------------------------------------------------------------
module tar_front #(
	parameter int MAX_RANK  = 4,
	parameter int ACC_DEPTH = 4096,
	parameter int DIM_BITS  = 10,
	parameter int AW        = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tar_pkg::cfg_t cfg,
	input  logic          restart,
	input  logic          accept,
	output logic [AW-1:0] slot,
	output tar_pkg::tag_t tag
);

	localparam int SZW  = DIM_BITS + 1;
	localparam int CW   = (SZW > tar_pkg::DIM_REG_W) ? SZW : tar_pkg::DIM_REG_W;
	localparam int RI_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam logic [CW-1:0] TOP = CW'(1 << DIM_BITS);

	logic [DIM_BITS-1:0] coord_q [MAX_RANK];
	logic [AW-1:0]       base_q  [MAX_RANK];
	logic [AW-1:0]       pos_q;

	logic [DIM_BITS-1:0] coord_next [MAX_RANK];
	logic [AW-1:0]       base_next  [MAX_RANK];
	logic [AW-1:0]       pos_next, pos_inc;
	logic [3:0]          rank_eff;
	logic [MAX_RANK-1:0] in_rank, mask_in, red, at_end, is_zero;
	logic [SZW-1:0]      size [MAX_RANK];
	logic                mask_any, found;
	logic [RI_W-1:0]     cd;

	always_comb begin
		if (cfg.rank == 3'd0)
			rank_eff = 4'd1;
		else if (int'(cfg.rank) > MAX_RANK)
			rank_eff = 4'(MAX_RANK);
		else
			rank_eff = {1'b0, cfg.rank};
	end

	for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
		logic [CW-1:0] raw, clamp;
		if (d < tar_pkg::NUM_DIM) begin : g_reg
			assign raw        = CW'(cfg.dim[d]);
			assign mask_in[d] = cfg.axis_mask[d] & in_rank[d];
		end else begin : g_fixed
			assign raw        = CW'(1);
			assign mask_in[d] = 1'b0;
		end
		assign in_rank[d] = (d < int'(rank_eff));
		always_comb begin
			if (!in_rank[d] || raw == '0)
				clamp = CW'(1);
			else if (raw > TOP)
				clamp = TOP;
			else
				clamp = raw;
		end
		assign size[d]    = SZW'(clamp);
		assign red[d]     = mask_any ? mask_in[d] : in_rank[d];
		assign at_end[d]  = (SZW'(coord_q[d]) + SZW'(1)) >= size[d];
		assign is_zero[d] = (coord_q[d] == '0);
	end

	assign mask_any     = |mask_in;
	assign tag.first    = &(~red | is_zero);
	assign tag.last_out = &(~red | at_end);
	assign tag.last_all = &at_end;
	assign slot         = pos_q;

	// Innermost dimension that does not wrap takes the carry. If it is reduced
	// the slot falls back to where this pass over it started, else it steps.
	always_comb begin
		found = 1'b0;
		cd    = '0;
		for (int d = 0; d < MAX_RANK; d++) begin
			if (!at_end[d]) begin
				found = 1'b1;
				cd    = RI_W'(d);
			end
		end
		pos_inc = (pos_q == AW'(ACC_DEPTH - 1)) ? '0 : pos_q + AW'(1);
		if (!found)
			pos_next = '0;
		else if (red[cd])
			pos_next = base_q[cd];
		else
			pos_next = pos_inc;
		for (int d = 0; d < MAX_RANK; d++) begin
			if (!found || d > int'(cd))
				coord_next[d] = '0;
			else if (d == int'(cd))
				coord_next[d] = coord_q[d] + DIM_BITS'(1);
			else
				coord_next[d] = coord_q[d];
			if (!found)
				base_next[d] = '0;
			else if (d >= int'(cd))
				base_next[d] = pos_next;
			else
				base_next[d] = base_q[d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int d = 0; d < MAX_RANK; d++) begin
				coord_q[d] <= '0;
				base_q[d]  <= '0;
			end
		end else if (restart) begin
			pos_q <= '0;
			for (int d = 0; d < MAX_RANK; d++) begin
				coord_q[d] <= '0;
				base_q[d]  <= '0;
			end
		end else if (accept) begin
			pos_q <= pos_next;
			for (int d = 0; d < MAX_RANK; d++) begin
				coord_q[d] <= coord_next[d];
				base_q[d]  <= base_next[d];
			end
		end
	end

endmodule

>>> rtl/tar_fifo.sv
// ----------------------------------------------------------------------------
// tar_fifo
// Short queue between the front end and the accumulate stage.
// ----------------------------------------------------------------------------
module tar_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0]         mem_q [tar_pkg::Q_DEPTH];
	logic [tar_pkg::Q_PW-1:0] wptr_q, rptr_q;
	logic [tar_pkg::Q_PW:0]   cnt_q;

	assign full  = (cnt_q == (tar_pkg::Q_PW+1)'(tar_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> rtl/tar_back.sv
// ----------------------------------------------------------------------------
// tar_back
// Accumulator memory read-modify-write with write forwarding, and the
// output register.
// ----------------------------------------------------------------------------
module tar_back #(
	parameter int ACC_DEPTH = 4096,
	parameter int AW        = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 mode,
	input  logic                       q_empty,
	input  logic [tar_pkg::VAL_W-1:0]  q_value,
	input  logic [AW-1:0]              q_slot,
	input  tar_pkg::tag_t              q_tag,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tar_pkg::ACC_W-1:0]  out_value,
	output logic [tar_pkg::IDX_W-1:0]  out_index,
	output logic                       out_last
);

	localparam int AccW = tar_pkg::ACC_W;

	logic [AccW-1:0]          acc_mem [ACC_DEPTH];

	logic                     valid_s1;
	logic [tar_pkg::VAL_W-1:0] value_s1;
	logic [AW-1:0]            slot_s1;
	tar_pkg::tag_t            tag_s1;
	logic [AccW-1:0]          rdata_s1, bypd_s1;
	logic                     byp_s1;

	logic                     out_valid_q, out_last_q;
	logic [AccW-1:0]          out_value_q;
	logic [tar_pkg::IDX_W-1:0] out_index_q;

	logic                     adv_s1;
	logic [AccW-1:0]          old_acc, acc_new, val_ext;
	logic [AccW:0]            sum_w;

	assign adv_s1 = valid_s1 && (!tag_s1.last_out || !out_valid_q || out_ready);
	assign q_pop  = !q_empty && (!valid_s1 || adv_s1);

	// read and write may hit one entry on the same edge; the read sees old data
	always_ff @(posedge clk) begin
		if (q_pop)
			rdata_s1 <= acc_mem[q_slot];
		if (adv_s1)
			acc_mem[slot_s1] <= acc_new;
	end

	assign old_acc = byp_s1 ? bypd_s1 : rdata_s1;
	assign val_ext = AccW'(signed'(value_s1));
	assign sum_w   = {old_acc[AccW-1], old_acc} + {val_ext[AccW-1], val_ext};

	always_comb begin
		case (mode)
			tar_pkg::MODE_ALL: begin
				acc_new = tag_s1.first ? AccW'(value_s1[0])
					: AccW'(old_acc[0] & value_s1[0]);
			end
			tar_pkg::MODE_ANY: begin
				acc_new = tag_s1.first ? AccW'(value_s1[7:0])
					: AccW'(old_acc[7:0] | value_s1[7:0]);
			end
			default: begin
				if (tag_s1.first)
					acc_new = val_ext;
				else if (sum_w[AccW] != sum_w[AccW-1])
					acc_new = sum_w[AccW] ? tar_pkg::ACC_MIN : tar_pkg::ACC_MAX;
				else
					acc_new = sum_w[AccW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (q_pop) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			value_s1 <= q_value;
			slot_s1  <= q_slot;
			tag_s1   <= q_tag;
			byp_s1   <= adv_s1 && (slot_s1 == q_slot);
			bypd_s1  <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && tag_s1.last_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && tag_s1.last_out) begin
			out_value_q <= acc_new;
			out_index_q <= tar_pkg::IDX_W'(slot_s1);
			out_last_q  <= tag_s1.last_all;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(slot_s1) && $stable(value_s1))
		else $error("accumulate stage lost its beat while stalled");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && tag_s1.last_out |=> out_valid_q)
		else $error("finished result not presented");

	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> valid_s1)
		else $error("popped beat did not reach accumulate stage");

endmodule

>>> rtl/tensor_axis_reduce.sv
// ----------------------------------------------------------------------------
// tensor_axis_reduce
// Streaming sum / all / any reduction of a tensor over selected axes.
// ----------------------------------------------------------------------------
// Usage:
//   Program mode, rank, axis mask and dimension sizes over APB while idle;
//   any register write to a defined index restarts the tensor walk at
//   element zero. Elements enter on s_t* in row-major order, one per beat.
//   A result beat leaves on m_t* when the last element feeding that output
//   arrives; m_tlast marks the result of the tensor's final element.
// Path and throughput:
//   Elements pass the queue, the accumulate stage and the output register.
//   One element per cycle is sustained unless m_tready stalls the output:
//   the accumulator memory does one read and one write a cycle, with the
//   entry written on the same edge as a read forwarded to the reader.
// Reset and stall:
//   Reset loads register defaults and clears coordinates and the queue;
//   the accumulator memory is not cleared, as each entry is written by the
//   first element of its output before it is read.
//   When m_tready is low the output register holds, the accumulate stage
//   stops, the four-beat queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
module tensor_axis_reduce #(
	parameter int MAX_RANK  = 4,
	parameter int ACC_DEPTH = 4096,
	parameter int DIM_BITS  = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [47:0] reduced_value, [59:48] output_index
	output logic        m_tlast,   // is_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int TW = $bits(tar_pkg::tag_t);
	localparam int QW = TW + AW + tar_pkg::VAL_W;

	tar_pkg::cfg_t cfg;
	tar_pkg::tag_t f_tag, q_tag;
	logic          restart, accept, q_full, q_empty, q_pop;
	logic [AW-1:0] f_slot, q_slot;
	logic [tar_pkg::VAL_W-1:0] q_value;
	logic [QW-1:0] q_wdata, q_rdata;
	logic [tar_pkg::ACC_W-1:0] r_value;
	logic [tar_pkg::IDX_W-1:0] r_index;

	assign s_tready = !q_full;
	assign accept   = s_tvalid & s_tready;

	tar_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.restart (restart)
	);

	tar_front #(
		.MAX_RANK  (MAX_RANK),
		.ACC_DEPTH (ACC_DEPTH),
		.DIM_BITS  (DIM_BITS),
		.AW        (AW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.accept  (accept),
		.slot    (f_slot),
		.tag     (f_tag)
	);

	assign q_wdata = {f_tag, f_slot, s_tdata};

	tar_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_value = q_rdata[tar_pkg::VAL_W-1:0];
	assign q_slot  = q_rdata[tar_pkg::VAL_W +: AW];
	assign q_tag   = q_rdata[QW-1 -: TW];

	tar_back #(
		.ACC_DEPTH (ACC_DEPTH),
		.AW        (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (cfg.mode),
		.q_empty   (q_empty),
		.q_value   (q_value),
		.q_slot    (q_slot),
		.q_tag     (q_tag),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (r_value),
		.out_index (r_index),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'b0, r_index, r_value};

endmodule

>>> tb/reduce_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reduce_checker
// Watches the APB port and both streams of tensor_axis_reduce. It keeps its
// own register copy, coordinate walk and accumulator memory, folds every
// accepted element into it, queues the result each finished output should
// give, and compares every result beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module reduce_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [tar_pkg::VAL_W-1:0]   s_tdata,    // [31:0] value
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [63:0]                 m_tdata,    // [47:0] reduced_value, [59:48] output_index
	input  logic                        m_tlast,    // is_last
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tar_pkg::ADDR_W-1:0]  paddr,
	input  logic [tar_pkg::DATA_W-1:0]  pwdata,
	input  logic                        pready,
	output int                          fail_count,
	output int                          pending
);

	localparam int          COORD_W  = 10;
	localparam int unsigned SPAN_MAX = 1 << COORD_W;
	localparam int          MEM_SIZE = 4096;
	localparam longint      SUM_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint      SUM_MIN  = -SUM_MAX - 1;

	typedef struct packed {
		logic [tar_pkg::ACC_W-1:0] value;
		logic [tar_pkg::IDX_W-1:0] index;
		logic                      last;
	} result_t;

	logic [1:0]                    mode_q;
	logic [2:0]                    rank_q;
	logic [3:0]                    mask_q;
	logic [tar_pkg::DIM_REG_W-1:0] dim_q [tar_pkg::NUM_DIM];
	logic [COORD_W-1:0]            coord [tar_pkg::NUM_DIM];
	logic [tar_pkg::ACC_W-1:0]     acc_mem [MEM_SIZE];
	result_t                       results_due [$];
	result_t                       due;
	logic                          restart;

	// register value as the block uses it: 0 counts as 1, big sizes clamp
	function automatic int unsigned span_of(input int i);
		int unsigned s;
		s = 32'(dim_q[i]);
		if (s < 1) s = 1;
		if (s > SPAN_MAX) s = SPAN_MAX;
		return s;
	endfunction

	task automatic fold_element(input logic [tar_pkg::VAL_W-1:0] raw);
		int unsigned               used;
		logic [3:0]                reduce;
		logic                      first, last_out, last_all, carry;
		longint unsigned           pos, stride;
		logic [tar_pkg::IDX_W-1:0] slot;
		longint                    total;
		logic [tar_pkg::ACC_W-1:0] acc;
		result_t                   entry;
		used = 32'(rank_q);
		if (used < 1) used = 1;
		if (used > tar_pkg::NUM_DIM) used = tar_pkg::NUM_DIM;
		reduce = mask_q & 4'((1 << used) - 1);
		// no reduced axis inside the rank: collapse the whole tensor
		if (reduce == 4'd0) reduce = 4'((1 << used) - 1);
		first    = 1'b1;
		last_out = 1'b1;
		last_all = 1'b1;
		pos      = 0;
		stride   = 1;
		for (int i = int'(used) - 1; i >= 0; i--) begin
			if (coord[i] + 1 < span_of(i)) last_all = 1'b0;
			if (reduce[i]) begin
				if (coord[i] != 0) first = 1'b0;
				if (coord[i] + 1 < span_of(i)) last_out = 1'b0;
			end else begin
				pos    += coord[i] * stride;
				stride *= span_of(i);
			end
		end
		slot = pos[tar_pkg::IDX_W-1:0];
		if (mode_q == tar_pkg::MODE_ALL) begin
			acc = first ? tar_pkg::ACC_W'(raw[0])
				: tar_pkg::ACC_W'(acc_mem[slot][0] & raw[0]);
		end else if (mode_q == tar_pkg::MODE_ANY) begin
			acc = first ? tar_pkg::ACC_W'(raw[7:0])
				: tar_pkg::ACC_W'(acc_mem[slot][7:0] | raw[7:0]);
		end else begin
			// unused mode code falls through to sum
			if (first) total = longint'($signed(raw));
			else total = longint'($signed(acc_mem[slot])) + longint'($signed(raw));
			if (total > SUM_MAX) total = SUM_MAX;
			if (total < SUM_MIN) total = SUM_MIN;
			acc = total[tar_pkg::ACC_W-1:0];
		end
		acc_mem[slot] = acc;
		carry = 1'b1;
		for (int i = int'(used) - 1; i >= 0; i--) begin
			if (carry) begin
				if (coord[i] + 1 >= span_of(i)) begin
					coord[i] = '0;
				end else begin
					coord[i] = coord[i] + 1'b1;
					carry    = 1'b0;
				end
			end
		end
		if (last_out) begin
			entry.value = acc;
			entry.index = slot;
			entry.last  = last_all;
			results_due = {results_due, entry};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = tar_pkg::MODE_SUM;
			rank_q = 3'd4;
			mask_q = 4'd0;
			foreach (dim_q[i]) dim_q[i] = 11'd1;
			foreach (coord[i]) coord[i] = '0;
			results_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				restart = 1'b1;
				case (paddr[4:2])
					tar_pkg::REG_MODE: mode_q   = pwdata[1:0];
					tar_pkg::REG_RANK: rank_q   = pwdata[2:0];
					tar_pkg::REG_MASK: mask_q   = pwdata[3:0];
					tar_pkg::REG_DIM0: dim_q[0] = pwdata[tar_pkg::DIM_REG_W-1:0];
					tar_pkg::REG_DIM1: dim_q[1] = pwdata[tar_pkg::DIM_REG_W-1:0];
					tar_pkg::REG_DIM2: dim_q[2] = pwdata[tar_pkg::DIM_REG_W-1:0];
					tar_pkg::REG_DIM3: dim_q[3] = pwdata[tar_pkg::DIM_REG_W-1:0];
					default:           restart  = 1'b0;
				endcase
				if (restart) foreach (coord[i]) coord[i] = '0;
			end
			if (s_tvalid && s_tready) fold_element(s_tdata);
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result beat with none expected, actual %h last %b",
						$time, m_tdata, m_tlast);
					fail_count++;
				end else begin
					due = results_due.pop_front();
					if (m_tdata[47:0] !== due.value) begin
						$display("%0t: reduced_value expected %h actual %h",
							$time, due.value, m_tdata[47:0]);
						fail_count++;
					end
					if (m_tdata[59:48] !== due.index) begin
						$display("%0t: output_index expected %h actual %h",
							$time, due.index, m_tdata[59:48]);
						fail_count++;
					end
					if (m_tlast !== due.last) begin
						$display("%0t: is_last expected %b actual %b",
							$time, due.last, m_tlast);
						fail_count++;
					end
				end
			end
			pending = results_due.size();
		end
	end

endmodule

>>> tb/tensor_axis_reduce_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tensor_axis_reduce_tb
// Drives tensor_axis_reduce through directed shapes and modes, a stalled
// output, then random shapes and elements with random gaps on both streams.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tensor_axis_reduce_tb;

	localparam int              HOLD_CYCLES    = 300;
	localparam int              WATCHDOG_LIMIT = 2000;
	localparam int              DRAIN_CYCLES   = 8;
	localparam logic [2:0]      REG_SPARE      = 3'd7;    // unmapped slot
	localparam logic [31:0]     SPARE_BITS     = 32'hFFFF_F800;

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [tar_pkg::VAL_W-1:0]  s_tdata  = '0;    // [31:0] value
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [63:0]                m_tdata;          // [47:0] reduced_value, [59:48] output_index
	logic                       m_tlast;          // is_last
	logic                       psel     = 1'b0;
	logic                       penable  = 1'b0;
	logic                       pwrite   = 1'b0;
	logic [tar_pkg::ADDR_W-1:0] paddr    = '0;
	logic [tar_pkg::DATA_W-1:0] pwdata   = '0;
	logic [tar_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	int hold_cycles  = 0;
	bit tx_idle      = 1'b1;
	bit rx_idle      = 1'b1;

	tensor_axis_reduce DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	reduce_checker u_reduce_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin : result_sink
		int gap;
		forever begin
			if (hold_cycles > 0) begin
				gap         = hold_cycles;
				hold_cycles = 0;
			end else begin
				gap = rx_idle ? int'($urandom_range(0, 7)) : 0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic write_reg(input logic [2:0] idx,
			input logic [tar_pkg::DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// junk above bit 10 must be dropped by every register
	task automatic set_shape(input logic [1:0] mode, input logic [2:0] rank,
			input logic [3:0] mask, input logic [10:0] d0, input logic [10:0] d1,
			input logic [10:0] d2, input logic [10:0] d3);
		write_reg(tar_pkg::REG_MODE, ($urandom() & SPARE_BITS) | 32'(mode));
		write_reg(tar_pkg::REG_RANK, ($urandom() & SPARE_BITS) | 32'(rank));
		write_reg(tar_pkg::REG_MASK, ($urandom() & SPARE_BITS) | 32'(mask));
		write_reg(tar_pkg::REG_DIM0, ($urandom() & SPARE_BITS) | 32'(d0));
		write_reg(tar_pkg::REG_DIM1, ($urandom() & SPARE_BITS) | 32'(d1));
		write_reg(tar_pkg::REG_DIM2, ($urandom() & SPARE_BITS) | 32'(d2));
		write_reg(tar_pkg::REG_DIM3, ($urandom() & SPARE_BITS) | 32'(d3));
	endtask

	task automatic send_beat(input logic [tar_pkg::VAL_W-1:0] value);
		int gap;
		gap = tx_idle ? int'($urandom_range(0, 7)) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
	endtask

	// wait for every due result, then let the pipe drain before new config
	task automatic settle(input bit rx_on, input int hold);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		rx_idle     = rx_on;
		hold_cycles = hold;
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [1:0]                mode;
		logic [2:0]                rank;
		logic [3:0]                mask;
		logic [10:0]               span [tar_pkg::NUM_DIM];
		logic [tar_pkg::VAL_W-1:0] value;
		int                        count;
		int                        pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset shape: every element is a whole scalar tensor
		send_beat(32'h7FFF_FFFF);
		send_beat(32'h8000_0000);
		send_beat(32'h0000_0000);
		send_beat(32'hFFFF_FFFF);
		settle(1'b1, 0);

		// mode 3 sums, rank 0 acts as 1, mask bits above the rank ignored
		set_shape(2'd3, 3'd0, 4'hE, 11'd3, 11'd1, 11'd1, 11'd1);
		repeat (3) send_beat($urandom());
		settle(1'b1, 0);

		set_shape(tar_pkg::MODE_ALL, 3'd2, 4'b0001, 11'd2, 11'd2, 11'd1, 11'd1);
		send_beat(32'h0000_00FF);
		send_beat(32'hFFFF_FF01);
		send_beat(32'h1234_5603);
		send_beat(32'h0000_00FE);
		settle(1'b1, 0);

		// rank 7 clamps to four, zero size acts as one
		set_shape(tar_pkg::MODE_ANY, 3'd7, 4'b1010, 11'd2, 11'd2, 11'd0, 11'd2);
		repeat (8) send_beat($urandom());
		settle(1'b1, 0);

		// a write to the unmapped slot must not restart the walk
		set_shape(tar_pkg::MODE_SUM, 3'd1, 4'd0, 11'd4, 11'd1, 11'd1, 11'd1);
		send_beat($urandom());
		send_beat($urandom());
		settle(1'b1, 0);
		write_reg(REG_SPARE, $urandom());
		send_beat($urandom());
		send_beat($urandom());
		settle(1'b1, HOLD_CYCLES);

		// output held off while every element closes an output
		set_shape(tar_pkg::MODE_SUM, 3'd2, 4'b0010, 11'd16, 11'd1, 11'd1, 11'd1);
		tx_idle = 1'b0;
		repeat (40) send_beat($urandom());
		settle(1'b0, 0);

		for (int p = 0; p < 12; p++) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			mode    = 2'($urandom_range(0, 3));
			rank    = 3'($urandom_range(0, 7));
			mask    = 4'($urandom_range(0, 15));
			foreach (span[i]) begin
				pick = int'($urandom_range(0, 9));
				if (pick == 0) span[i] = 11'd0;
				else if (pick == 9) span[i] = 11'($urandom_range(5, 12));
				else span[i] = 11'($urandom_range(1, 4));
			end
			set_shape(mode, rank, mask, span[0], span[1], span[2], span[3]);
			count = int'($urandom_range(40, 80));
			repeat (count) begin
				pick = int'($urandom_range(0, 9));
				if (pick == 0) value = 32'h7FFF_FFFF;
				else if (pick == 1) value = 32'h8000_0000;
				else value = $urandom();
				// keep bit 0 mostly set so AND results are not always zero
				if (mode == tar_pkg::MODE_ALL && pick > 1)
					value[0] = ($urandom_range(0, 15) != 0);
				send_beat(value);
			end
			settle($urandom_range(0, 3) != 0, 0);
		end

		settle(1'b1, 0);
		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> tensor_axis_reduce.f
rtl/tar_pkg.sv
rtl/tar_cfg.sv
rtl/tar_front.sv
rtl/tar_fifo.sv
rtl/tar_back.sv
rtl/tensor_axis_reduce.sv
tb/reduce_checker.sv
tb/tensor_axis_reduce_tb.sv
